// ===== rtl/dlhc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlhc_pkg
// Types, constants and helpers shared by the display list hazard checker.
// ----------------------------------------------------------------------------
package dlhc_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int COMMAND_LIMIT = 200000;
  localparam int SEGMENT_COUNT = 16;

  localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W   = $clog2(COMMAND_LIMIT + 1);
  localparam int SEG_AW  = $clog2(SEGMENT_COUNT);

  localparam logic [31:0] ADDR_UNKNOWN    = 32'hffff_ffff;
  localparam logic [2:0]  SIZE_UNKNOWN    = 3'd4;
  localparam logic [12:0] SCISSOR_UNKNOWN = 13'h1000;
  localparam logic [31:0] LOW_ADDR_LIMIT  = 32'h400;
  localparam logic [31:0] CYCLE_MASK      = 32'h30_0000;
  localparam logic [17:0] LOAD_BITS_LIMIT = 18'd464;

  localparam logic CMD_START   = 1'b0;

  localparam logic [1:0] CFG_LIST_START = 2'd0;
  localparam logic [1:0] CFG_LIST_BYTES = 2'd1;
  localparam logic [1:0] CFG_RAM_SIZE   = 2'd2;

  localparam logic [1:0] ST_PARTIAL = 2'd0;
  localparam logic [1:0] ST_HAZARD  = 2'd1;
  localparam logic [1:0] ST_CHECKED = 2'd2;

  localparam logic [4:0] RS_FILL_4BIT      = 5'd0;
  localparam logic [4:0] RS_FILL_IMAGE     = 5'd1;
  localparam logic [4:0] RS_FILL_ZCMP      = 5'd2;
  localparam logic [4:0] RS_FILL_ZUPD      = 5'd3;
  localparam logic [4:0] RS_COPY_32BIT     = 5'd4;
  localparam logic [4:0] RS_COPY_SCISSOR   = 5'd5;
  localparam logic [4:0] RS_CMD_LIMIT      = 5'd6;
  localparam logic [4:0] RS_BAD_MASTER     = 5'd7;
  localparam logic [4:0] RS_NO_END         = 5'd8;
  localparam logic [4:0] RS_BAD_ADDR       = 5'd9;
  localparam logic [4:0] RS_BAD_RECT       = 5'd10;
  localparam logic [4:0] RS_UNTERM_TRI     = 5'd11;
  localparam logic [4:0] RS_TRI_LEN        = 5'd12;
  localparam logic [4:0] RS_UNSUP_HALF     = 5'd13;
  localparam logic [4:0] RS_UNKNOWN_SEG    = 5'd14;
  localparam logic [4:0] RS_STACK_LIMIT    = 5'd15;
  localparam logic [4:0] RS_CHECKED        = 5'd16;
  localparam logic [4:0] RS_COND_CULL      = 5'd17;
  localparam logic [4:0] RS_SEG_OFFSET     = 5'd18;
  localparam logic [4:0] RS_MODE_MASK      = 5'd19;
  localparam logic [4:0] RS_4BIT_LOAD      = 5'd20;
  localparam logic [4:0] RS_REV_TLUT       = 5'd21;
  localparam logic [4:0] RS_MISALIGN_LOAD  = 5'd22;
  localparam logic [4:0] RS_BAD_DMA        = 5'd23;
  localparam logic [4:0] RS_UNSUP_CMD      = 5'd24;

  localparam logic [7:0] OP_NOOP     = 8'h00;
  localparam logic [7:0] OP_VTX      = 8'h01;
  localparam logic [7:0] OP_MOVEMEM3 = 8'h03;
  localparam logic [7:0] OP_MOVEMEM4 = 8'h04;
  localparam logic [7:0] OP_DL       = 8'h06;
  localparam logic [7:0] OP_TRI2     = 8'hb1;
  localparam logic [7:0] OP_RDPHALF3 = 8'hb2;
  localparam logic [7:0] OP_RDPHALF2 = 8'hb3;
  localparam logic [7:0] OP_RDPHALF1 = 8'hb4;
  localparam logic [7:0] OP_B6       = 8'hb6;
  localparam logic [7:0] OP_B7       = 8'hb7;
  localparam logic [7:0] OP_ENDDL    = 8'hb8;
  localparam logic [7:0] OP_SETOML   = 8'hb9;
  localparam logic [7:0] OP_SETOMH   = 8'hba;
  localparam logic [7:0] OP_BB       = 8'hbb;
  localparam logic [7:0] OP_MOVEWORD = 8'hbc;
  localparam logic [7:0] OP_BD       = 8'hbd;
  localparam logic [7:0] OP_CULLDL   = 8'hbe;
  localparam logic [7:0] OP_TRI1     = 8'hbf;
  localparam logic [7:0] OP_C0       = 8'hc0;
  localparam logic [7:0] OP_TEXRECT  = 8'he4;
  localparam logic [7:0] OP_TEXRECTF = 8'he5;
  localparam logic [7:0] OP_SCISSOR  = 8'hed;
  localparam logic [7:0] OP_OTHERM   = 8'hef;
  localparam logic [7:0] OP_LOADTLUT = 8'hf0;
  localparam logic [7:0] OP_F2       = 8'hf2;
  localparam logic [7:0] OP_LOADBLK  = 8'hf3;
  localparam logic [7:0] OP_LOADTILE = 8'hf4;
  localparam logic [7:0] OP_F5       = 8'hf5;
  localparam logic [7:0] OP_FILLRECT = 8'hf6;
  localparam logic [7:0] OP_SETTIMG  = 8'hfd;
  localparam logic [7:0] OP_FE       = 8'hfe;
  localparam logic [7:0] OP_SETCIMG  = 8'hff;
  localparam logic [7:0] MW_SEGMENT  = 8'h06;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word_high;
    logic [31:0] word_low;
    logic        read_ok;
  } dlhc_in_t;

  typedef struct packed {
    logic        done_res;
    logic [31:0] fetch_address;
    logic [1:0]  status;
    logic [4:0]  reason;
    logic [31:0] fault_address;
    logic [31:0] fault_word_high;
    logic [31:0] fault_word_low;
    logic [31:0] caller_address;
    logic [17:0] command_count;
  } dlhc_out_t;

  typedef struct packed {
    logic [31:0] list_start;
    logic [31:0] list_bytes;
    logic [31:0] ram_size;
  } dlhc_cfg_t;

  typedef struct packed {
    logic              seg_we;
    logic [SEG_AW-1:0] seg_waddr;
    logic [23:0]       seg_wdata;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr;
    logic [31:0]       ret_wdata;
    logic [31:0]       caller_wdata;
    logic [STK_AW-1:0] stk_raddr_top;
    logic [STK_AW-1:0] stk_raddr_below;
  } dlhc_mem_ctl_t;

  function automatic logic in_range(input logic [31:0] a, input logic [31:0] n,
                                    input logic [31:0] lim);
    in_range = (a >= LOW_ADDR_LIMIT) && (a < lim) && (n <= lim - a);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dlhc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlhc_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dlhc_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlhc_walker
// Walk state and per-command checks; updates state on each evaluated item.
// ----------------------------------------------------------------------------
module dlhc_walker
  import dlhc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire dlhc_in_t      item,
  input  wire dlhc_cfg_t     cfg,
  input  wire logic [23:0]   seg_rdata,
  input  wire logic [31:0]   ret_rdata,
  input  wire logic [31:0]   caller_top,
  input  wire logic [31:0]   caller_below,
  output dlhc_mem_ctl_t      mem_ctl,
  output dlhc_out_t          result
);

  logic [31:0]        pc_r, pc_nxt;
  logic [31:0]        root_start_r, root_start_nxt;
  logic [31:0]        root_end_r, root_end_nxt;
  logic [15:0]        seg_known_r, seg_known_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [31:0]        mode_high_r, mode_high_nxt;
  logic [31:0]        mode_low_r, mode_low_nxt;
  logic [31:0]        hmask_r, hmask_nxt;
  logic [31:0]        lmask_r, lmask_nxt;
  logic [31:0]        tex_addr_r, tex_addr_nxt;
  logic [2:0]         tex_size_r, tex_size_nxt;
  logic [2:0]         color_size_r, color_size_nxt;
  logic [12:0]        scissor_r, scissor_nxt;
  logic [5:0]         half_index_r, half_index_nxt;
  logic [5:0]         half_total_r, half_total_nxt;
  logic [1:0]         rect_left_r, rect_left_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               verdict_r, verdict_nxt;
  logic               walking_r, walking_nxt;
  logic [1:0]         fin_status_r, fin_status_nxt;
  logic [4:0]         fin_reason_r, fin_reason_nxt;
  logic [31:0]        last_addr_r, last_addr_nxt;
  logic [31:0]        last_hi_r, last_hi_nxt;
  logic [31:0]        last_lo_r, last_lo_nxt;
  logic [31:0]        last_caller_r, last_caller_nxt;

  // draw hazard on the current mode state
  logic       dh_hit;
  logic [4:0] dh_code;
  logic [1:0] cyc;

  always_comb begin
    dh_hit  = 1'b0;
    dh_code = RS_FILL_4BIT;
    cyc     = mode_high_r[21:20];
    if ((hmask_r & CYCLE_MASK) == CYCLE_MASK) begin
      if (cyc == 2'd3) begin
        if (color_size_r == 3'd0) begin
          dh_hit = 1'b1; dh_code = RS_FILL_4BIT;
        end else if ((mode_low_r & lmask_r & 32'h40) != 32'd0) begin
          dh_hit = 1'b1; dh_code = RS_FILL_IMAGE;
        end else if ((mode_low_r & lmask_r & 32'h10) != 32'd0) begin
          dh_hit = 1'b1; dh_code = RS_FILL_ZCMP;
        end else if ((lmask_r & 32'h24) == 32'h24 && (mode_low_r & 32'h24) == 32'h20) begin
          dh_hit = 1'b1; dh_code = RS_FILL_ZUPD;
        end
      end else if (cyc == 2'd2) begin
        if (color_size_r == 3'd3) begin
          dh_hit = 1'b1; dh_code = RS_COPY_32BIT;
        end else if (scissor_r != SCISSOR_UNKNOWN && scissor_r != 13'd0) begin
          dh_hit = 1'b1; dh_code = RS_COPY_SCISSOR;
        end
      end
    end
  end

  logic [31:0] w0, w1, pc8, seg_addr, mask, pix, tex_sum;
  logic [7:0]  op, sh, sz, exp_op;
  logic [15:0] mw_off, dma_len;
  logic [5:0]  sub, hi_nxt;
  logic [17:0] load_bits;
  logic        seg_ok, fin, do_adv, pushed, popped;
  logic [1:0]  fst;
  logic [4:0]  frs;
  logic [31:0] top_new;

  always_comb begin
    pc_nxt          = pc_r;
    root_start_nxt  = root_start_r;
    root_end_nxt    = root_end_r;
    seg_known_nxt   = seg_known_r;
    depth_nxt       = depth_r;
    mode_high_nxt   = mode_high_r;
    mode_low_nxt    = mode_low_r;
    hmask_nxt       = hmask_r;
    lmask_nxt       = lmask_r;
    tex_addr_nxt    = tex_addr_r;
    tex_size_nxt    = tex_size_r;
    color_size_nxt  = color_size_r;
    scissor_nxt     = scissor_r;
    half_index_nxt  = half_index_r;
    half_total_nxt  = half_total_r;
    rect_left_nxt   = rect_left_r;
    cnt_nxt         = cnt_r;
    verdict_nxt     = verdict_r;
    walking_nxt     = walking_r;
    fin_status_nxt  = fin_status_r;
    fin_reason_nxt  = fin_reason_r;
    last_addr_nxt   = last_addr_r;
    last_hi_nxt     = last_hi_r;
    last_lo_nxt     = last_lo_r;
    last_caller_nxt = last_caller_r;

    mem_ctl                 = '0;
    mem_ctl.stk_waddr       = depth_r[STK_AW-1:0];
    mem_ctl.stk_raddr_top   = STK_AW'(depth_r - DEPTH_W'(1));
    mem_ctl.stk_raddr_below = STK_AW'(depth_r - DEPTH_W'(2));
    mem_ctl.seg_waddr       = item.word_high[13:10];
    mem_ctl.seg_wdata       = item.word_low[23:0];
    mem_ctl.ret_wdata       = pc_r + 32'd8;
    mem_ctl.caller_wdata    = last_addr_r;

    fin    = 1'b0;
    fst    = ST_PARTIAL;
    frs    = RS_FILL_4BIT;
    do_adv = 1'b0;
    pushed = 1'b0;
    popped = 1'b0;

    w0       = item.word_high;
    w1       = item.word_low;
    op       = w0[31:24];
    pc8      = pc_r + 32'd8;
    seg_ok   = seg_known_r[w1[27:24]];
    seg_addr = {8'd0, w1[23:0]} + {8'd0, seg_rdata};
    sh       = w0[15:8];
    sz       = w0[7:0];
    mask     = (32'hffff_ffff >> (6'd32 - sz[5:0])) << sh[4:0];
    mw_off   = w0[23:8];
    dma_len  = w0[15:0];
    sub      = w1[29:24];
    hi_nxt   = half_index_r + 6'd1;
    exp_op   = (rect_left_r == 2'd2) ? OP_RDPHALF1 : OP_RDPHALF2;
    if (op == OP_LOADBLK) begin
      pix = 32'(w1[23:12]) + 32'd1;
    end else begin
      pix = 32'(w1[23:14]) - 32'(w0[23:14]) + 32'd1;
    end
    load_bits = 18'(pix[12:0]) << ({1'b0, tex_size_r[1:0]} + 3'd2);
    tex_sum   = tex_addr_r & 32'hf;

    if (item.cmd == CMD_START) begin
      pc_nxt          = '0;
      root_start_nxt  = '0;
      root_end_nxt    = '0;
      seg_known_nxt   = '0;
      depth_nxt       = '0;
      mode_high_nxt   = '0;
      mode_low_nxt    = '0;
      hmask_nxt       = '0;
      lmask_nxt       = '0;
      tex_addr_nxt    = ADDR_UNKNOWN;
      tex_size_nxt    = SIZE_UNKNOWN;
      color_size_nxt  = SIZE_UNKNOWN;
      scissor_nxt     = SCISSOR_UNKNOWN;
      half_index_nxt  = '0;
      half_total_nxt  = '0;
      rect_left_nxt   = '0;
      cnt_nxt         = '0;
      verdict_nxt     = 1'b0;
      walking_nxt     = 1'b1;
      fin_status_nxt  = '0;
      fin_reason_nxt  = '0;
      last_addr_nxt   = '0;
      last_hi_nxt     = '0;
      last_lo_nxt     = '0;
      last_caller_nxt = '0;
      if (cfg.list_start[2:0] != 3'd0 || cfg.list_bytes == 32'd0 ||
          cfg.list_bytes[2:0] != 3'd0 ||
          !in_range(cfg.list_start, cfg.list_bytes, cfg.ram_size)) begin
        last_addr_nxt = cfg.list_start;
        fin = 1'b1; fst = ST_HAZARD; frs = RS_BAD_MASTER;
      end else begin
        pc_nxt         = cfg.list_start;
        root_start_nxt = cfg.list_start;
        root_end_nxt   = cfg.list_start + cfg.list_bytes;
        do_adv         = 1'b1;
      end
    end else if (!verdict_r && walking_r) begin
      if (!item.read_ok) begin
        last_hi_nxt = '0;
        last_lo_nxt = '0;
        fin = 1'b1; fst = ST_HAZARD; frs = RS_BAD_ADDR;
      end else begin
        last_hi_nxt = w0;
        last_lo_nxt = w1;
        cnt_nxt     = cnt_r + CNT_W'(1);
        pc_nxt      = pc8;
        if (rect_left_r != 2'd0) begin
          if (op != exp_op) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_BAD_RECT;
          end else begin
            rect_left_nxt = rect_left_r - 2'd1;
          end
        end else if (half_index_r != 6'd0) begin
          if (!(op inside {OP_RDPHALF1, OP_RDPHALF3, OP_RDPHALF2})) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_UNTERM_TRI;
          end else begin
            half_index_nxt = hi_nxt;
            if (hi_nxt > half_total_r || (op == OP_RDPHALF2 && hi_nxt != half_total_r) ||
                (hi_nxt == half_total_r && op != OP_RDPHALF2)) begin
              fin = 1'b1; fst = ST_HAZARD; frs = RS_TRI_LEN;
            end else if (op == OP_RDPHALF2) begin
              half_index_nxt = '0;
            end
          end
        end else if (op == OP_RDPHALF1) begin
          if (sub < 6'd8 || sub > 6'd15) begin
            fin = 1'b1; fst = ST_PARTIAL; frs = RS_UNSUP_HALF;
          end else begin
            half_total_nxt = 6'd8 + (sub[2] ? 6'd16 : 6'd0) + (sub[1] ? 6'd16 : 6'd0) +
                             (sub[0] ? 6'd4 : 6'd0);
            half_index_nxt = 6'd1;
            if (dh_hit) begin
              fin = 1'b1; fst = ST_HAZARD; frs = dh_code;
            end
          end
        end else if (op == OP_DL) begin
          if (!seg_ok) begin
            fin = 1'b1; fst = ST_PARTIAL; frs = RS_UNKNOWN_SEG;
          end else begin
            if (w0[23:16] == 8'd0) begin
              if (32'(depth_r) >= 32'(STACK_DEPTH)) begin
                fin = 1'b1; fst = ST_PARTIAL; frs = RS_STACK_LIMIT;
              end else begin
                mem_ctl.stk_we = 1'b1;
                depth_nxt      = depth_r + DEPTH_W'(1);
                pushed         = 1'b1;
              end
            end else if (depth_r == '0) begin
              root_start_nxt = '0;
              root_end_nxt   = cfg.ram_size;
            end
            if (!fin) begin
              pc_nxt = seg_addr;
            end
          end
        end else if (op == OP_ENDDL) begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - DEPTH_W'(1);
            pc_nxt    = ret_rdata;
            popped    = 1'b1;
          end else begin
            fin = 1'b1; fst = ST_CHECKED; frs = RS_CHECKED;
          end
        end else if (op == OP_CULLDL) begin
          fin = 1'b1; fst = ST_PARTIAL; frs = RS_COND_CULL;
        end else if (op == OP_MOVEWORD && w0[7:0] == MW_SEGMENT) begin
          if (mw_off[1:0] != 2'd0 || mw_off >= 16'd64) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_SEG_OFFSET;
          end else begin
            mem_ctl.seg_we = 1'b1;
            seg_known_nxt[mw_off[5:2]] = 1'b1;
          end
        end else if (op == OP_SETOMH || op == OP_SETOML) begin
          if (sz == 8'd0 || sh >= 8'd32 || (9'(sz) + 9'(sh)) > 9'd32) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_MODE_MASK;
          end else if (op == OP_SETOMH) begin
            mode_high_nxt = (mode_high_r & ~mask) | w1;
            hmask_nxt     = hmask_r | mask;
          end else begin
            mode_low_nxt = (mode_low_r & ~mask) | w1;
            lmask_nxt    = lmask_r | mask;
          end
        end else if (op == OP_OTHERM) begin
          mode_high_nxt = {8'd0, w0[23:0]};
          mode_low_nxt  = w1;
          hmask_nxt     = 32'hffff_ffff;
          lmask_nxt     = 32'hffff_ffff;
        end else if (op == OP_SETTIMG) begin
          tex_addr_nxt = seg_ok ? seg_addr : ADDR_UNKNOWN;
          tex_size_nxt = {1'b0, w0[20:19]};
        end else if (op == OP_SETCIMG) begin
          color_size_nxt = {1'b0, w0[20:19]};
        end else if (op == OP_SCISSOR) begin
          scissor_nxt = {1'b0, w0[23:12]};
        end else if (op inside {OP_LOADTILE, OP_LOADBLK, OP_LOADTLUT}) begin
          if (op != OP_LOADBLK && tex_size_r == 3'd0) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_4BIT_LOAD;
          end else if (op == OP_LOADTLUT && w0[23:14] > w1[23:14]) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_REV_TLUT;
          end else if (op != OP_LOADTLUT && tex_addr_r != ADDR_UNKNOWN &&
                       tex_sum > 32'd0 && tex_sum < 32'd8 &&
                       tex_size_r > 3'd0 && tex_size_r <= 3'd3 &&
                       pix <= 32'd4096 && load_bits >= LOAD_BITS_LIMIT) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_MISALIGN_LOAD;
          end
        end else if (op inside {OP_VTX, OP_MOVEMEM3, OP_MOVEMEM4}) begin
          if (seg_ok && (seg_addr[2:0] != 3'd0 || dma_len == 16'd0 ||
              !in_range(seg_addr, 32'(dma_len), cfg.ram_size))) begin
            fin = 1'b1; fst = ST_HAZARD; frs = RS_BAD_DMA;
          end
        end else if (op inside {OP_FILLRECT, OP_TEXRECT, OP_TEXRECTF, OP_TRI1, OP_TRI2}) begin
          if (dh_hit) begin
            fin = 1'b1; fst = ST_HAZARD; frs = dh_code;
          end else if (op == OP_TEXRECT || op == OP_TEXRECTF) begin
            rect_left_nxt = 2'd2;
          end
        end else if (!(op inside {OP_NOOP, OP_MOVEWORD, OP_BB, OP_BD, OP_B6, OP_B7, OP_C0,
                                  [8'he6:8'hee], OP_F2, OP_F5, [8'hf7:8'hfc], OP_FE})) begin
          fin = 1'b1; fst = ST_PARTIAL; frs = RS_UNSUP_CMD;
        end
      end
      do_adv = !fin;
    end

    // caller of the innermost list after this command
    if (pushed) begin
      top_new = last_addr_r;
    end else if (popped) begin
      top_new = caller_below;
    end else begin
      top_new = caller_top;
    end

    if (do_adv) begin
      if (32'(cnt_nxt) >= 32'(COMMAND_LIMIT)) begin
        fin = 1'b1; fst = ST_PARTIAL; frs = RS_CMD_LIMIT;
      end else begin
        last_addr_nxt   = pc_nxt;
        last_caller_nxt = (depth_nxt != '0) ? top_new : 32'd0;
        if (depth_nxt == '0 && (pc_nxt < root_start_nxt || pc_nxt >= root_end_nxt)) begin
          last_hi_nxt = '0;
          last_lo_nxt = '0;
          fin = 1'b1; fst = ST_HAZARD; frs = RS_NO_END;
        end else if (pc_nxt[2:0] != 3'd0 || !in_range(pc_nxt, 32'd8, cfg.ram_size)) begin
          last_hi_nxt = '0;
          last_lo_nxt = '0;
          fin = 1'b1; fst = ST_HAZARD; frs = RS_BAD_ADDR;
        end
      end
    end

    if (fin) begin
      verdict_nxt    = 1'b1;
      fin_status_nxt = fst;
      fin_reason_nxt = frs;
    end

    if (verdict_nxt) begin
      result.done_res        = 1'b1;
      result.fetch_address   = '0;
      result.status          = fin_status_nxt;
      result.reason          = fin_reason_nxt;
      result.fault_address   = last_addr_nxt;
      result.fault_word_high = last_hi_nxt;
      result.fault_word_low  = last_lo_nxt;
    end else begin
      result.done_res        = 1'b0;
      result.fetch_address   = pc_nxt;
      result.status          = ST_PARTIAL;
      result.reason          = '0;
      result.fault_address   = pc_nxt;
      result.fault_word_high = '0;
      result.fault_word_low  = '0;
    end
    result.caller_address = last_caller_nxt;
    result.command_count  = 18'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= '0;
      root_start_r  <= '0;
      root_end_r    <= '0;
      seg_known_r   <= '0;
      depth_r       <= '0;
      mode_high_r   <= '0;
      mode_low_r    <= '0;
      hmask_r       <= '0;
      lmask_r       <= '0;
      tex_addr_r    <= ADDR_UNKNOWN;
      tex_size_r    <= SIZE_UNKNOWN;
      color_size_r  <= SIZE_UNKNOWN;
      scissor_r     <= SCISSOR_UNKNOWN;
      half_index_r  <= '0;
      half_total_r  <= '0;
      rect_left_r   <= '0;
      cnt_r         <= '0;
      verdict_r     <= 1'b0;
      walking_r     <= 1'b0;
      fin_status_r  <= '0;
      fin_reason_r  <= '0;
      last_addr_r   <= '0;
      last_hi_r     <= '0;
      last_lo_r     <= '0;
      last_caller_r <= '0;
    end else if (fire) begin
      pc_r          <= pc_nxt;
      root_start_r  <= root_start_nxt;
      root_end_r    <= root_end_nxt;
      seg_known_r   <= seg_known_nxt;
      depth_r       <= depth_nxt;
      mode_high_r   <= mode_high_nxt;
      mode_low_r    <= mode_low_nxt;
      hmask_r       <= hmask_nxt;
      lmask_r       <= lmask_nxt;
      tex_addr_r    <= tex_addr_nxt;
      tex_size_r    <= tex_size_nxt;
      color_size_r  <= color_size_nxt;
      scissor_r     <= scissor_nxt;
      half_index_r  <= half_index_nxt;
      half_total_r  <= half_total_nxt;
      rect_left_r   <= rect_left_nxt;
      cnt_r         <= cnt_nxt;
      verdict_r     <= verdict_nxt;
      walking_r     <= walking_nxt;
      fin_status_r  <= fin_status_nxt;
      fin_reason_r  <= fin_reason_nxt;
      last_addr_r   <= last_addr_nxt;
      last_hi_r     <= last_hi_nxt;
      last_lo_r     <= last_lo_nxt;
      last_caller_r <= last_caller_nxt;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(STACK_DEPTH))
    else $error("call stack depth beyond limit");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(COMMAND_LIMIT))
    else $error("command counter beyond limit");
  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire && verdict_r && item.cmd != CMD_START |=> verdict_r && $stable(fin_reason_r))
    else $error("verdict changed without start");
`endif

endmodule
`default_nettype wire

// ===== rtl/display_list_hazard_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// display_list_hazard_checker
// Walks a display list one command per transaction and reports the next
// fetch address or a sticky hazard verdict.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   dlhc_in_t   start or fetched command
//   out_     out  out_valid/out_stall dlhc_out_t  fetch request or verdict
//   cfg_     in   cfg_valid/cfg_ready index, data register write
//
// Each transaction reads the segment and stack RAMs, then evaluates the
// command and writes back state. A new transaction is taken only once
// the previous one has been evaluated; the result register lets the next
// one in while a result waits on out_stall.
// Reset is synchronous; segment and stack RAMs are not cleared.
// ----------------------------------------------------------------------------
module display_list_hazard_checker
  import dlhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire dlhc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dlhc_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  dlhc_cfg_t     cfg_r;
  dlhc_in_t      item_r;
  logic          busy_r;
  logic          out_valid_r;
  dlhc_out_t     out_data_r;
  logic          accept, fire;
  dlhc_mem_ctl_t mem_ctl;
  dlhc_out_t     result;
  logic [23:0]   seg_rdata;
  logic [31:0]   ret_rdata, caller_top, caller_below;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  assign fire      = busy_r && !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.list_start <= '0;
      cfg_r.list_bytes <= '0;
      cfg_r.ram_size   <= 32'd8388608;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIST_START: cfg_r.list_start <= cfg_data;
        CFG_LIST_BYTES: cfg_r.list_bytes <= cfg_data;
        CFG_RAM_SIZE:   cfg_r.ram_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  dlhc_ram #(.WIDTH(24), .DEPTH(SEGMENT_COUNT), .AW(SEG_AW)) u_seg_ram (
    .clk   (clk),
    .we    (fire && mem_ctl.seg_we),
    .waddr (mem_ctl.seg_waddr),
    .wdata (mem_ctl.seg_wdata),
    .re    (accept),
    .raddr (in_data.word_low[27:24]),
    .rdata (seg_rdata)
  );

  dlhc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(STK_AW)) u_ret_ram (
    .clk   (clk),
    .we    (fire && mem_ctl.stk_we),
    .waddr (mem_ctl.stk_waddr),
    .wdata (mem_ctl.ret_wdata),
    .re    (accept),
    .raddr (mem_ctl.stk_raddr_top),
    .rdata (ret_rdata)
  );

  // caller stack kept twice for two read addresses
  dlhc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(STK_AW)) u_caller_ram_a (
    .clk   (clk),
    .we    (fire && mem_ctl.stk_we),
    .waddr (mem_ctl.stk_waddr),
    .wdata (mem_ctl.caller_wdata),
    .re    (accept),
    .raddr (mem_ctl.stk_raddr_top),
    .rdata (caller_top)
  );

  dlhc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(STK_AW)) u_caller_ram_b (
    .clk   (clk),
    .we    (fire && mem_ctl.stk_we),
    .waddr (mem_ctl.stk_waddr),
    .wdata (mem_ctl.caller_wdata),
    .re    (accept),
    .raddr (mem_ctl.stk_raddr_below),
    .rdata (caller_below)
  );

  dlhc_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (item_r),
    .cfg          (cfg_r),
    .seg_rdata    (seg_rdata),
    .ret_rdata    (ret_rdata),
    .caller_top   (caller_top),
    .caller_below (caller_below),
    .mem_ctl      (mem_ctl),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !accept)
    else $error("transaction accepted while one is in evaluation");
  a_fetch_zero_in_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> out_data_r.fetch_address == 32'd0)
    else $error("verdict carries a fetch address");
  a_fetch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res |->
      out_data_r.fault_address == out_data_r.fetch_address && out_data_r.reason == 5'd0)
    else $error("fetch request fields inconsistent");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status != 2'd3)
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire
